>>> sv/ela3d_pkg.sv
package ela3d_pkg;

    // input coordinates and edge vectors
    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int EDGE_W    = COORD_W + 1;
    localparam int OUT_W     = 40;

    // shared multiplier and accumulators
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;

    // angle path
    localparam int SHR_W  = 31;            // shrunk component, magnitude below 2^30
    localparam int CRS_W  = 62;            // cross and dot magnitudes
    localparam int ROOT_W = PROD_W / 2;    // square root digits
    localparam int CORD_W = 44;            // cordic x and y
    localparam int ANG_W  = 44;            // angle accumulator, 2^-32 degree units
    localparam int CORDIC_STEPS = 32;
    localparam int STEP_W = $clog2(CORDIC_STEPS);

    localparam int FIFO_DEPTH = 2;

    localparam logic signed [ANG_W-1:0] DEG90  = ANG_W'(64'sd386547056640);
    localparam logic signed [ANG_W-1:0] DEG180 = ANG_W'(64'sd773094113280);
    localparam logic [63:0] DEG_PER_RAD = 64'd246083499208;

    typedef enum logic [1:0] {
        MODE_LEN   = 2'd0,
        MODE_STORE = 2'd1,
        MODE_ANGLE = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        OP_LEN,
        OP_ANGLE,
        OP_FAIL
    } op_t;

    typedef logic signed [EDGE_W-1:0] edge_t;
    typedef logic signed [SHR_W-1:0]  shr_t;

    // one queued job: stored edge f and current edge e
    typedef struct packed {
        op_t   op;
        edge_t ex;
        edge_t ey;
        edge_t ez;
        edge_t fx;
        edge_t fy;
        edge_t fz;
    } job_t;

    function automatic logic [EDGE_W-1:0] edge_mag(input edge_t v);
        logic [EDGE_W-1:0] m;
        m = v[EDGE_W-1] ? EDGE_W'(-v) : EDGE_W'(v);
        return m;
    endfunction

    // right shift that brings every component below 2^30
    function automatic logic [1:0] shrink_shift(input logic [EDGE_W-1:0] orm);
        logic [1:0] s;
        if (orm[EDGE_W-1])
            s = 2'd3;
        else if (orm[EDGE_W-2])
            s = 2'd2;
        else if (orm[EDGE_W-3])
            s = 2'd1;
        else
            s = 2'd0;
        return s;
    endfunction

    // magnitude truncated by the shift, sign put back
    function automatic shr_t shrink_comp(input edge_t v, input logic [1:0] s);
        logic [EDGE_W-1:0] q;
        shr_t r;
        q = edge_mag(v) >> s;
        r = shr_t'(q[SHR_W-1:0]);
        return v[EDGE_W-1] ? -r : r;
    endfunction

    // atan(2^-i) in 2^-32 degree units
    function automatic logic signed [ANG_W-1:0] step_angle(input logic [STEP_W-1:0] i);
        logic [63:0] t;
        logic signed [ANG_W-1:0] r;
        t = 64'd0;
        unique case (i)
            5'd0:  r = ANG_W'(64'sd193273528320);
            5'd1:  r = ANG_W'(64'sd114096026022);
            5'd2:  r = ANG_W'(64'sd60285206653);
            5'd3:  r = ANG_W'(64'sd30601712202);
            5'd4:  r = ANG_W'(64'sd15360239180);
            5'd5:  r = ANG_W'(64'sd7687607525);
            5'd6:  r = ANG_W'(64'sd3844741810);
            5'd7:  r = ANG_W'(64'sd1922488225);
            5'd8:  r = ANG_W'(64'sd961258780);
            5'd9:  r = ANG_W'(64'sd480631223);
            5'd10: r = ANG_W'(64'sd240315841);
            5'd11: r = ANG_W'(64'sd120157949);
            5'd12: r = ANG_W'(64'sd60078978);
            5'd13: r = ANG_W'(64'sd30039490);
            5'd14: r = ANG_W'(64'sd15019745);
            5'd15: r = ANG_W'(64'sd7509872);
            default:
            begin
                // small angles: deg per rad scaled by 2^-i, rounded
                t = (DEG_PER_RAD + (64'd1 << (i - 5'd1))) >> i;
                r = ANG_W'(t);
            end
        endcase
        return r;
    endfunction

endpackage

>>> sv/edge_length_and_angle_3d.sv
// channel   direction  handshake              payload
// command   in         start, busy            mode, start_x..z, end_x..z, points_valid
// result    out        done (one-cycle)       result_value, result_ok
//
// a length word runs the square root unit (one digit a cycle); an angle word also runs
// the cross/dot scaling, which takes up to 32 steps, and the 32-step cordic, so the time
// to its done depends on the data.
// store words and words of mode 3 give no result and finish on acceptance.
// busy rises only while the two-word queue between front and back is full.
// reset is asynchronous, active low; it clears the stored edge and the queue.
// the receiver cannot stall: done is high for one cycle per result word.
module edge_length_and_angle_3d (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           mode,
    input  logic signed [31:0]   start_x,
    input  logic signed [31:0]   start_y,
    input  logic signed [31:0]   start_z,
    input  logic signed [31:0]   end_x,
    input  logic signed [31:0]   end_y,
    input  logic signed [31:0]   end_z,
    input  logic                 points_valid,
    output logic                 done,
    output logic [39:0]          result_value,
    output logic                 result_ok
);
    import ela3d_pkg::*;

    logic push, pop, full, empty;
    job_t push_job, head;

    // front: edge vector, stored edge, classification of the word
    ela3d_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .full         (full),
        .mode         (mode),
        .start_x      (start_x),
        .start_y      (start_y),
        .start_z      (start_z),
        .end_x        (end_x),
        .end_y        (end_y),
        .end_z        (end_z),
        .points_valid (points_valid),
        .push         (push),
        .job          (push_job)
    );

    // short queue decoupling front and back
    ela3d_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    // back: multiplier program, normalization, square root, cordic
    ela3d_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .head         (head),
        .pop          (pop),
        .done         (done),
        .result_value (result_value),
        .result_ok    (result_ok)
    );

    assign busy = full;

    // a failed word always carries a zero value
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result_ok |-> result_value == '0)
        else $error("failed result with nonzero value");

    // the queue never takes a word while full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    // the back never pops an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

endmodule

>>> sv/ela3d_front.sv
module ela3d_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  full,
    input  logic [1:0]            mode,
    input  logic signed [31:0]    start_x,
    input  logic signed [31:0]    start_y,
    input  logic signed [31:0]    start_z,
    input  logic signed [31:0]    end_x,
    input  logic signed [31:0]    end_y,
    input  logic signed [31:0]    end_z,
    input  logic                  points_valid,
    output logic                  push,
    output ela3d_pkg::job_t       job
);
    import ela3d_pkg::*;

    edge_t fx_reg, fy_reg, fz_reg;
    logic  fvalid_reg;
    edge_t ex, ey, ez;
    logic  accept;
    logic  e_nz, f_nz;

    assign accept = start && !full;

    assign ex = edge_t'(end_x) - edge_t'(start_x);
    assign ey = edge_t'(end_y) - edge_t'(start_y);
    assign ez = edge_t'(end_z) - edge_t'(start_z);

    assign e_nz = (ex | ey | ez) != '0;
    assign f_nz = (fx_reg | fy_reg | fz_reg) != '0;

    // only length and angle words produce a result
    assign push = accept && (mode == MODE_LEN || mode == MODE_ANGLE);

    always_comb
    begin
        job.ex = ex;
        job.ey = ey;
        job.ez = ez;
        job.fx = fx_reg;
        job.fy = fy_reg;
        job.fz = fz_reg;
        if (mode == MODE_LEN)
            job.op = points_valid ? OP_LEN : OP_FAIL;
        else
            job.op = (points_valid && fvalid_reg && e_nz && f_nz) ? OP_ANGLE : OP_FAIL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fx_reg     <= '0;
            fy_reg     <= '0;
            fz_reg     <= '0;
            fvalid_reg <= 1'b0;
        end
        else if (accept && mode == MODE_STORE)
        begin
            fx_reg     <= ex;
            fy_reg     <= ey;
            fz_reg     <= ez;
            fvalid_reg <= points_valid;
        end
    end

endmodule

>>> sv/ela3d_fifo.sv
module ela3d_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ela3d_pkg::job_t  push_job,
    input  logic             pop,
    output ela3d_pkg::job_t  head,
    output logic             full,
    output logic             empty
);
    import ela3d_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    job_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = count_reg == CNT_W'(FIFO_DEPTH);
    assign empty = count_reg == '0;
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

>>> sv/ela3d_sqrt.sv
module ela3d_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ela3d_pkg::PROD_W-1:0]  radicand,
    output logic                          done,
    output logic [ela3d_pkg::ROOT_W:0]    root
);
    import ela3d_pkg::*;

    localparam int REM_W = ROOT_W + 4;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [PROD_W-1:0] rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] q_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              run_reg;
    logic              done_reg;
    logic [ROOT_W:0]   root_reg;

    logic [REM_W-1:0]  rem_sh, trial;
    logic              take;

    // one root digit per cycle, restoring form
    assign rem_sh = {rem_reg[REM_W-3:0], rad_reg[PROD_W-1 -: 2]};
    assign trial  = {{(REM_W-ROOT_W-2){1'b0}}, q_reg, 2'b01};
    assign take   = rem_sh >= trial;

    assign done = done_reg;
    assign root = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad_reg  <= '0;
            rem_reg  <= '0;
            q_reg    <= '0;
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            root_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rad_reg <= radicand;
                rem_reg <= '0;
                q_reg   <= '0;
                cnt_reg <= '0;
                run_reg <= 1'b1;
            end
            else if (run_reg)
            begin
                if (cnt_reg == CNT_W'(ROOT_W))
                begin
                    // round half up: remainder above root means past midpoint
                    root_reg <= {1'b0, q_reg} +
                                ((rem_reg > REM_W'(q_reg)) ? (ROOT_W+1)'(1) : '0);
                    done_reg <= 1'b1;
                    run_reg  <= 1'b0;
                end
                else
                begin
                    rad_reg <= rad_reg << 2;
                    rem_reg <= take ? rem_sh - trial : rem_sh;
                    q_reg   <= {q_reg[ROOT_W-2:0], take};
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

endmodule

>>> sv/ela3d_back.sv
module ela3d_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          empty,
    input  ela3d_pkg::job_t               head,
    output logic                          pop,
    output logic                          done,
    output logic [ela3d_pkg::OUT_W-1:0]   result_value,
    output logic                          result_ok
);
    import ela3d_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHRINK,
        S_MUL,
        S_MAG,
        S_NORM,
        S_SQRT,
        S_CORDIC,
        S_FINAL
    } state_t;

    typedef enum logic [1:0] {
        PRG_LEN,
        PRG_CROSS,
        PRG_SQ
    } prog_t;

    localparam logic [CRS_W-1:0] NORM_LIMIT = CRS_W'(1) << 30;
    localparam logic [CRS_W-1:0] NORM_FLOOR = CRS_W'(1) << 29;

    state_t state_reg;
    prog_t  prog_reg;
    job_t   job_reg;
    logic [3:0] cnt_reg;
    shr_t   u_reg [3];
    shr_t   v_reg [3];
    logic signed [PROD_W-1:0] prod_reg;
    logic [1:0] tgt_reg;
    logic       neg_reg;
    logic       pvalid_reg;
    logic signed [PROD_W-1:0] acc_reg [4];
    logic [CRS_W-1:0] n_reg [4];
    logic       dneg_reg;
    logic       sq_start_reg;
    logic signed [CORD_W-1:0] x_reg, y_reg;
    logic signed [ANG_W-1:0]  z_reg;
    logic [STEP_W-1:0] step_reg;
    logic       done_reg;
    logic [OUT_W-1:0] value_reg;
    logic       ok_reg;

    logic signed [MUL_W-1:0] opa, opb;
    logic [1:0] tgt;
    logic       neg;
    logic [3:0] nprod;
    edge_t      ev [3];
    edge_t      fv [3];
    logic [1:0] sel;
    logic [EDGE_W-1:0] sq_mag;
    logic [1:0] su, sv;
    logic [CRS_W-1:0] orv;
    logic       sq_done;
    logic [ROOT_W:0] sq_root;
    logic signed [CORD_W-1:0] sx, sy;
    logic signed [ANG_W-1:0]  sa;
    logic signed [ANG_W-1:0]  zc, zr;
    logic [OUT_W-1:0] ang_val;

    assign pop = (state_reg == S_IDLE) && !empty;

    assign ev[0] = job_reg.ex;
    assign ev[1] = job_reg.ey;
    assign ev[2] = job_reg.ez;
    assign fv[0] = job_reg.fx;
    assign fv[1] = job_reg.fy;
    assign fv[2] = job_reg.fz;

    assign su = shrink_shift(edge_mag(fv[0]) | edge_mag(fv[1]) | edge_mag(fv[2]));
    assign sv = shrink_shift(edge_mag(ev[0]) | edge_mag(ev[1]) | edge_mag(ev[2]));

    assign sel    = cnt_reg[1:0];
    assign sq_mag = edge_mag(ev[sel]);
    assign nprod  = (prog_reg == PRG_CROSS) ? 4'd9 : 4'd3;

    // product program: squares for length and norm, cross and dot for the angle
    always_comb
    begin
        opa = '0;
        opb = '0;
        tgt = 2'd0;
        neg = 1'b0;
        unique case (prog_reg)
            PRG_LEN:
            begin
                opa = MUL_W'({1'b0, sq_mag});
                opb = opa;
            end
            PRG_SQ:
            begin
                opa = MUL_W'({1'b0, n_reg[sel][MUL_W-2:0]});
                opb = opa;
            end
            PRG_CROSS:
            begin
                unique case (cnt_reg)
                    4'd0: begin opa = MUL_W'(u_reg[1]); opb = MUL_W'(v_reg[2]); end
                    4'd1: begin opa = MUL_W'(u_reg[2]); opb = MUL_W'(v_reg[1]); neg = 1'b1; end
                    4'd2: begin opa = MUL_W'(u_reg[2]); opb = MUL_W'(v_reg[0]); tgt = 2'd1; end
                    4'd3:
                    begin
                        opa = MUL_W'(u_reg[0]); opb = MUL_W'(v_reg[2]); tgt = 2'd1; neg = 1'b1;
                    end
                    4'd4: begin opa = MUL_W'(u_reg[0]); opb = MUL_W'(v_reg[1]); tgt = 2'd2; end
                    4'd5:
                    begin
                        opa = MUL_W'(u_reg[1]); opb = MUL_W'(v_reg[0]); tgt = 2'd2; neg = 1'b1;
                    end
                    4'd6: begin opa = MUL_W'(u_reg[0]); opb = MUL_W'(v_reg[0]); tgt = 2'd3; end
                    4'd7: begin opa = MUL_W'(u_reg[1]); opb = MUL_W'(v_reg[1]); tgt = 2'd3; end
                    4'd8: begin opa = MUL_W'(u_reg[2]); opb = MUL_W'(v_reg[2]); tgt = 2'd3; end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign orv = n_reg[0] | n_reg[1] | n_reg[2] | n_reg[3];

    assign sx = x_reg >>> step_reg;
    assign sy = y_reg >>> step_reg;
    assign sa = step_angle(step_reg);

    // clamp to [0, 180] degrees, round to output fraction
    always_comb
    begin
        if (z_reg < 0)
            zc = '0;
        else if (z_reg > DEG180)
            zc = DEG180;
        else
            zc = z_reg;
        zr = zc + (ANG_W'(1) << (31 - FRAC_BITS));
        ang_val = OUT_W'(zr >>> (32 - FRAC_BITS));
    end

    ela3d_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start_reg),
        .radicand (PROD_W'(acc_reg[0])),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign done         = done_reg;
    assign result_value = value_reg;
    assign result_ok    = ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            prog_reg     <= PRG_LEN;
            job_reg      <= '0;
            cnt_reg      <= '0;
            u_reg        <= '{default: '0};
            v_reg        <= '{default: '0};
            prod_reg     <= '0;
            tgt_reg      <= '0;
            neg_reg      <= 1'b0;
            pvalid_reg   <= 1'b0;
            acc_reg      <= '{default: '0};
            n_reg        <= '{default: '0};
            dneg_reg     <= 1'b0;
            sq_start_reg <= 1'b0;
            x_reg        <= '0;
            y_reg        <= '0;
            z_reg        <= '0;
            step_reg     <= '0;
            done_reg     <= 1'b0;
            value_reg    <= '0;
            ok_reg       <= 1'b0;
        end
        else
        begin
            done_reg     <= 1'b0;
            sq_start_reg <= 1'b0;
            pvalid_reg   <= 1'b0;

            if (pvalid_reg)
                acc_reg[tgt_reg] <= neg_reg ? acc_reg[tgt_reg] - prod_reg
                                            : acc_reg[tgt_reg] + prod_reg;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (!empty)
                    begin
                        job_reg <= head;
                        acc_reg <= '{default: '0};
                        cnt_reg <= '0;
                        unique case (head.op)
                            OP_LEN:
                            begin
                                prog_reg  <= PRG_LEN;
                                state_reg <= S_MUL;
                            end
                            OP_ANGLE:
                                state_reg <= S_SHRINK;
                            default:
                            begin
                                done_reg  <= 1'b1;
                                value_reg <= '0;
                                ok_reg    <= 1'b0;
                            end
                        endcase
                    end
                end
                S_SHRINK:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        u_reg[k] <= shrink_comp(fv[k], su);
                        v_reg[k] <= shrink_comp(ev[k], sv);
                    end
                    prog_reg  <= PRG_CROSS;
                    cnt_reg   <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    if (cnt_reg == nprod)
                    begin
                        if (prog_reg == PRG_CROSS)
                            state_reg <= S_MAG;
                        else
                            state_reg <= S_SQRT;
                    end
                    else
                    begin
                        prod_reg   <= opa * opb;
                        tgt_reg    <= tgt;
                        neg_reg    <= neg;
                        pvalid_reg <= 1'b1;
                        cnt_reg    <= cnt_reg + 1'b1;
                    end
                end
                S_MAG:
                begin
                    for (int k = 0; k < 4; k++)
                        n_reg[k] <= acc_reg[k][PROD_W-1] ? CRS_W'(-acc_reg[k])
                                                         : CRS_W'(acc_reg[k]);
                    dneg_reg  <= acc_reg[3][PROD_W-1];
                    state_reg <= S_NORM;
                end
                S_NORM:
                begin
                    priority if (orv == '0)
                    begin
                        // parallel edges with nothing left after scaling
                        done_reg  <= 1'b1;
                        value_reg <= '0;
                        ok_reg    <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (orv >= NORM_LIMIT)
                    begin
                        for (int k = 0; k < 4; k++)
                            n_reg[k] <= n_reg[k] >> 1;
                    end
                    else if (orv < NORM_FLOOR)
                    begin
                        for (int k = 0; k < 4; k++)
                            n_reg[k] <= n_reg[k] << 1;
                    end
                    else
                    begin
                        acc_reg   <= '{default: '0};
                        prog_reg  <= PRG_SQ;
                        cnt_reg   <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_SQRT:
                begin
                    if (cnt_reg == nprod && !pvalid_reg)
                    begin
                        sq_start_reg <= 1'b1;
                        cnt_reg      <= '0;
                    end
                    if (sq_done)
                    begin
                        if (prog_reg == PRG_LEN)
                        begin
                            done_reg  <= 1'b1;
                            value_reg <= OUT_W'(sq_root);
                            ok_reg    <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            // rotate a negative dot product into the right half plane
                            if (dneg_reg)
                            begin
                                x_reg <= CORD_W'(sq_root);
                                y_reg <= {1'b0, n_reg[3][CORD_W-2:0]};
                                z_reg <= DEG90;
                            end
                            else
                            begin
                                x_reg <= {1'b0, n_reg[3][CORD_W-2:0]};
                                y_reg <= CORD_W'(sq_root);
                                z_reg <= '0;
                            end
                            step_reg  <= '0;
                            state_reg <= S_CORDIC;
                        end
                    end
                end
                S_CORDIC:
                begin
                    if (y_reg >= 0)
                    begin
                        x_reg <= x_reg + sy;
                        y_reg <= y_reg - sx;
                        z_reg <= z_reg + sa;
                    end
                    else
                    begin
                        x_reg <= x_reg - sy;
                        y_reg <= y_reg + sx;
                        z_reg <= z_reg - sa;
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                        state_reg <= S_FINAL;
                end
                S_FINAL:
                begin
                    done_reg  <= 1'b1;
                    value_reg <= ang_val;
                    ok_reg    <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
